[design/assert_macros.svh]
// Assertion helpers; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/cbd_pkg.sv]
package cbd_pkg;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] out_byte;
   } res_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_COLON = 8'h3A;

   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.val = 4'(b - 8'h61 + 8'd10);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.val = 4'(b - 8'h41 + 8'd10);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic logic is_lws(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB);
   endfunction

endpackage

[design/chunked_body_decoder_unit.sv]
// A req beat reaches rsp_valid through the input register, then the result register.
// Throughput: one byte per cycle unless rsp_ready stalls; all parsing is a single combinational pass per byte.
// A byte that produces no result is consumed without a rsp beat.
// Reset (synchronous, active high) empties both registers and returns the parser
// to the size line start; req_restart clears the parser state at the start of a body.
`include "assert_macros.svh"

module chunked_body_decoder_unit #(
   parameter int SIZE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_restart,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output cbd_pkg::kind_type rsp_kind
);
   import cbd_pkg::*;

   logic       in_vld_ff;
   logic [7:0] in_data_ff;
   logic       in_restart_ff;
   logic       advance;
   res_type    res;
   logic       out_vld_ff;
   logic [7:0] out_byte_ff;
   kind_type   out_kind_ff;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   cbd_parser #(
      .SIZE_BITS(SIZE_BITS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .data_byte(in_data_ff),
      .restart  (in_restart_ff),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (advance) begin
            out_vld_ff <= res.valid;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff    <= req_data_byte;
         in_restart_ff <= req_restart;
      end
      if (advance && res.valid) begin
         out_byte_ff <= res.out_byte;
         out_kind_ff <= res.kind;
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_kind     = out_kind_ff;

   `ASSERT_CLK(a_stage_holds, clock, reset, in_vld_ff && !advance |=> in_vld_ff, "held beat dropped from input stage")
   `ASSERT_CLK(a_byte_zero, clock, reset, out_vld_ff && out_kind_ff != KIND_PAYLOAD |-> out_byte_ff == 8'd0, "nonzero byte on end or error beat")
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !in_vld_ff && !out_vld_ff, "stages not empty after reset")

endmodule

[design/cbd_parser.sv]
`include "assert_macros.svh"

module cbd_parser #(
   parameter int SIZE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [7:0]       data_byte,
   input  logic             restart,
   output cbd_pkg::res_type res
);
   import cbd_pkg::*;

   typedef enum logic [2:0] {
      PH_LWS, PH_DIGITS, PH_REST, PH_DATA, PH_DCR, PH_DLF, PH_TRL, PH_TRL_EOL
   } phase_type;

   typedef struct packed {
      logic cp;
      logic le;
      logic cs;
      logic done;
      logic eol;
   } trl_type;

   phase_type              phase_ff, phase_in;
   logic [SIZE_BITS-1:0]   remaining_ff, remaining_in;
   logic                   digit_ff, digit_in;
   logic                   cr_ff, cr_in;
   logic                   empty_ff, empty_in;
   logic                   colon_ff, colon_in;
   logic                   halted_ff, halted_in;
   logic                   emit;
   kind_type               kind;
   hex_type                hx;
   trl_type                tr;

   function automatic trl_type trailer_step(input logic [7:0] b, input logic cp,
                                            input logic le, input logic cs);
      trl_type t;
      t.cp   = cp;
      t.le   = le;
      t.cs   = cs;
      t.done = 1'b0;
      t.eol  = 1'b0;
      if (cp) begin
         t.cp = 1'b0;
         if (b == CH_LF) begin
            if (le) begin
               t.done = 1'b1;
            end else begin
               t.eol = 1'b1;
            end
         end else begin
            t.le = 1'b0;
         end
      end
      if (!t.done && !t.eol) begin
         if (b == CH_CR) begin
            t.cp = 1'b1;
         end else begin
            t.le = 1'b0;
            if (b == CH_COLON) begin
               t.cs = 1'b1;
            end
         end
      end
      return t;
   endfunction

   always_comb begin
      phase_in     = restart ? PH_LWS : phase_ff;
      remaining_in = restart ? '0 : remaining_ff;
      digit_in     = restart ? 1'b0 : digit_ff;
      cr_in        = restart ? 1'b0 : cr_ff;
      empty_in     = restart ? 1'b1 : empty_ff;
      colon_in     = restart ? 1'b0 : colon_ff;
      halted_in    = restart ? 1'b0 : halted_ff;
      emit         = 1'b0;
      kind         = KIND_PAYLOAD;
      hx           = hex_decode(data_byte);
      tr           = '0;
      if (!halted_in) begin
         if ((phase_in == PH_LWS || phase_in == PH_DIGITS) && hx.ok) begin
            phase_in = PH_DIGITS;
            if (remaining_in[SIZE_BITS-1 -: 4] != 4'd0) begin
               emit = 1'b1;
               kind = KIND_ERROR;
            end else begin
               remaining_in = {remaining_in[SIZE_BITS-5:0], hx.val};
               digit_in     = 1'b1;
            end
         end else if (phase_in == PH_LWS && is_lws(data_byte)) begin
            phase_in = PH_LWS;
         end else if (phase_in == PH_LWS || phase_in == PH_DIGITS ||
                      phase_in == PH_REST) begin
            phase_in = PH_REST;
            if (cr_in && data_byte == CH_LF) begin
               cr_in = 1'b0;
               if (!digit_in) begin
                  emit = 1'b1;
                  kind = KIND_ERROR;
               end else if (remaining_in == '0) begin
                  phase_in = PH_TRL;
                  empty_in = 1'b1;
                  colon_in = 1'b0;
               end else begin
                  phase_in = PH_DATA;
               end
            end else begin
               cr_in = (data_byte == CH_CR);
            end
         end else begin
            case (phase_in)
               PH_DATA: begin
                  emit         = 1'b1;
                  kind         = KIND_PAYLOAD;
                  remaining_in = remaining_in - SIZE_BITS'(1);
                  if (remaining_in == '0) begin
                     phase_in = PH_DCR;
                  end
               end
               PH_DCR: begin
                  if (data_byte == CH_CR) begin
                     phase_in = PH_DLF;
                  end else begin
                     emit = 1'b1;
                     kind = KIND_ERROR;
                  end
               end
               PH_DLF: begin
                  if (data_byte == CH_LF) begin
                     phase_in     = PH_LWS;
                     digit_in     = 1'b0;
                     remaining_in = '0;
                  end else begin
                     emit = 1'b1;
                     kind = KIND_ERROR;
                  end
               end
               PH_TRL: begin
                  tr = trailer_step(data_byte, cr_in, empty_in, colon_in);
               end
               PH_TRL_EOL: begin
                  if (is_lws(data_byte)) begin
                     // folded line keeps the line flags
                     phase_in = PH_TRL;
                     tr.cp    = cr_in;
                     tr.le    = empty_in;
                     tr.cs    = colon_in;
                  end else if (!colon_in) begin
                     emit = 1'b1;
                     kind = KIND_ERROR;
                  end else begin
                     phase_in = PH_TRL;
                     tr = trailer_step(data_byte, cr_in, 1'b1, 1'b0);
                  end
               end
               default: begin
                  phase_in = PH_LWS;
               end
            endcase
            if (phase_in == PH_TRL && !emit) begin
               cr_in    = tr.cp;
               empty_in = tr.le;
               colon_in = tr.cs;
               if (tr.done) begin
                  emit = 1'b1;
                  kind = KIND_DONE;
               end else if (tr.eol) begin
                  phase_in = PH_TRL_EOL;
               end
            end
         end
         if (emit && kind != KIND_PAYLOAD) begin
            halted_in = 1'b1;
         end
      end
      res.valid    = fire && emit;
      res.kind     = kind;
      res.out_byte = (kind == KIND_PAYLOAD) ? data_byte : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LWS;
         remaining_ff <= '0;
         digit_ff     <= 1'b0;
         cr_ff        <= 1'b0;
         empty_ff     <= 1'b1;
         colon_ff     <= 1'b0;
         halted_ff    <= 1'b0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         digit_ff     <= digit_in;
         cr_ff        <= cr_in;
         empty_ff     <= empty_in;
         colon_ff     <= colon_in;
         halted_ff    <= halted_in;
      end
   end

   `ASSERT_CLK(a_halt_after_end, clock, reset, fire && res.valid && res.kind != KIND_PAYLOAD |=> halted_ff, "end or error beat did not halt decoding")
   `ASSERT_CLK(a_quiet_when_halted, clock, reset, halted_ff && !(fire && restart) |-> !res.valid, "result while halted")
   `ASSERT_CLK(a_data_count, clock, reset, !halted_ff && phase_ff == PH_DATA |-> remaining_ff != '0, "payload phase with zero count")

endmodule
